>>> sv/mec_pkg.sv
// Package for the magnetic event classifier: mode codes, configuration and
// result structs, register indexes and stream widths. No dependencies.
`default_nettype none

package mec_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int LEVEL_W    = 11;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CROSSINGS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CROSSINGS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RISING        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FALLING       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LATEST_MIN_TIME   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LATEST_MAX_TIME   = 3'd6;

    typedef enum logic [1:0] {
        MODE_CAL     = 2'd0,
        MODE_WATCH   = 2'd1,
        MODE_CAPTURE = 2'd2
    } t_mode;

    typedef logic signed [LEVEL_W-1:0] t_level;

    typedef struct packed {
        logic [SAMPLE_W-1:0] trigger_threshold;
        logic [COUNT_W-1:0]  min_crossings;
        logic [COUNT_W-1:0]  max_crossings;
        logic [COUNT_W-1:0]  min_rising;
        logic [COUNT_W-1:0]  max_falling;
        logic [COUNT_W-1:0]  latest_min_time;
        logic [COUNT_W-1:0]  latest_max_time;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         phase;
        logic               event_started;
        logic               event_done;
        logic               detected;
        t_level             deviation;
        logic [COUNT_W-1:0] crossings;
        logic [COUNT_W-1:0] rising_count;
        logic [COUNT_W-1:0] falling_count;
        logic [COUNT_W-1:0] min_time;
        logic [COUNT_W-1:0] max_time;
    } t_result;

endpackage

`default_nettype wire

>>> sv/magnetic_event_classifier_top.sv
// Magnetic event classifier, top level: stream ports, input and result registers.
// Accepted samples go to the input register, their results to the result register.
// Throughput: one item per cycle unless the output side stalls; the input register
// and result register decouple the two sides, mec_core's per-item logic between.
// Reset: synchronous, active low; restores register reset values and restarts
// calibration of the baseline.
`default_nettype none

module magnetic_event_classifier_top #(
    parameter int CALIBRATION_SAMPLES = 5,
    parameter int SAMPLES_PER_WINDOW  = 4,
    parameter int WINDOWS             = 49
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: [9:0] sample
    input  wire logic [mec_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // tdata: [1:0] phase, [2] event_started, [3] detected, [14:4] deviation,
    // [20:15] crossings, [26:21] rising_count, [32:27] falling_count,
    // [38:33] min_time, [44:39] max_time
    output logic [mec_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // tlast: event_done
    output logic                                o_m_axis_tlast,
    input  wire logic                           i_cfg_we,
    input  wire logic [mec_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [mec_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mec_pkg::*;

    t_cfg                w_cfg;
    t_result             w_result;
    logic                w_step;
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    t_result             r_out;

    mec_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    mec_core #(
        .CALIBRATION_SAMPLES (CALIBRATION_SAMPLES),
        .SAMPLES_PER_WINDOW  (SAMPLES_PER_WINDOW),
        .WINDOWS             (WINDOWS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_step),
        .i_sample (r_in_sample),
        .o_result (w_result)
    );

    assign w_step          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) r_in_valid <= i_s_axis_tvalid;
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) r_in_sample <= i_s_axis_tdata[SAMPLE_W-1:0];
        if (w_step) r_out <= w_result;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out.event_done;
    assign o_m_axis_tdata  = {3'b000, r_out.max_time, r_out.min_time, r_out.falling_count,
                              r_out.rising_count, r_out.crossings, r_out.deviation,
                              r_out.detected, r_out.event_started, r_out.phase};

endmodule

`default_nettype wire

>>> sv/mec_cfg_regs.sv
// Configuration register file of the magnetic event classifier.
// Depends on mec_pkg for register indexes and the t_cfg struct.
`default_nettype none

module mec_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mec_pkg::t_cfg                      o_cfg
);
    import mec_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_threshold <= 10'd5;
            r_cfg.min_crossings     <= 6'd2;
            r_cfg.max_crossings     <= 6'd7;
            r_cfg.min_rising        <= 6'd10;
            r_cfg.max_falling       <= 6'd30;
            r_cfg.latest_min_time   <= 6'd30;
            r_cfg.latest_max_time   <= 6'd45;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRIGGER_THRESHOLD: r_cfg.trigger_threshold <= i_cfg_data;
                CFG_MIN_CROSSINGS:     r_cfg.min_crossings     <= i_cfg_data[COUNT_W-1:0];
                CFG_MAX_CROSSINGS:     r_cfg.max_crossings     <= i_cfg_data[COUNT_W-1:0];
                CFG_MIN_RISING:        r_cfg.min_rising        <= i_cfg_data[COUNT_W-1:0];
                CFG_MAX_FALLING:       r_cfg.max_falling       <= i_cfg_data[COUNT_W-1:0];
                CFG_LATEST_MIN_TIME:   r_cfg.latest_min_time   <= i_cfg_data[COUNT_W-1:0];
                CFG_LATEST_MAX_TIME:   r_cfg.latest_max_time   <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> sv/mec_cdiv.sv
// Floor division of an unsigned value by a constant, by reciprocal multiply.
// Exact below 2**IN_W when the quotient fits OUT_W bits. No dependencies.
`default_nettype none

module mec_cdiv #(
    parameter int DIVISOR = 4,
    parameter int IN_W    = 14,
    parameter int OUT_W   = 10
) (
    input  wire logic [IN_W-1:0]  i_dividend,
    output logic      [OUT_W-1:0] o_quotient
);
    // error term stays below 2**SH for all inputs, so the floor is exact
    localparam int SH     = IN_W + $clog2(DIVISOR) + 1;
    localparam int PROD_W = IN_W + SH + 1;
    localparam logic [SH:0] RECIP = (SH+1)'(((64'd1 << SH) + DIVISOR - 1) / DIVISOR);

    logic [PROD_W-1:0] w_prod;

    assign w_prod     = PROD_W'(i_dividend) * PROD_W'(RECIP);
    assign o_quotient = w_prod[SH +: OUT_W];

endmodule

`default_nettype wire

>>> sv/mec_core.sv
// Per-item logic and event state of the magnetic event classifier:
// calibration, trigger, window averaging, counters and verdict.
// Depends on mec_pkg and mec_cdiv.
`default_nettype none

module mec_core #(
    parameter int CALIBRATION_SAMPLES = 5,
    parameter int SAMPLES_PER_WINDOW  = 4,
    parameter int WINDOWS             = 49
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mec_pkg::t_cfg               i_cfg,
    input  wire logic                        i_step,
    input  wire logic [mec_pkg::SAMPLE_W-1:0] i_sample,
    output mec_pkg::t_result                 o_result
);
    import mec_pkg::*;

    localparam int CNT_MAX   = (CALIBRATION_SAMPLES > SAMPLES_PER_WINDOW) ?
                               CALIBRATION_SAMPLES : SAMPLES_PER_WINDOW;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);
    localparam int CAL_SUM_W = $clog2(CALIBRATION_SAMPLES * 1023 + 1);
    localparam int WIN_SUM_W = $clog2(SAMPLES_PER_WINDOW * 1023 + 1);
    localparam logic [CNT_W-1:0]   CAL_N    = CNT_W'(CALIBRATION_SAMPLES);
    localparam logic [CNT_W-1:0]   SPW_N    = CNT_W'(SAMPLES_PER_WINDOW);
    localparam logic [COUNT_W-1:0] WIN_LAST = COUNT_W'(WINDOWS);

    t_mode                r_mode, n_mode;
    logic [SAMPLE_W-1:0]  r_baseline, n_baseline;
    logic [CAL_SUM_W-1:0] r_cal_sum, n_cal_sum;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [COUNT_W-1:0]   r_win_idx, n_win_idx;
    logic [WIN_SUM_W-1:0] r_win_sum, n_win_sum;
    t_level               r_prev, n_prev;
    t_level               r_peak, n_peak;
    t_level               r_trough, n_trough;
    logic [COUNT_W-1:0]   r_peak_win, n_peak_win;
    logic [COUNT_W-1:0]   r_trough_win, n_trough_win;
    logic [COUNT_W-1:0]   r_rise, n_rise;
    logic [COUNT_W-1:0]   r_fall, n_fall;
    logic [COUNT_W-1:0]   r_cross, n_cross;

    logic [CNT_W-1:0]     w_cnt_inc;
    logic [CAL_SUM_W-1:0] w_cal_sum_inc;
    logic [WIN_SUM_W-1:0] w_win_sum_inc;
    logic [SAMPLE_W-1:0]  w_cal_avg, w_win_avg;
    logic                 w_cal_end, w_win_end, w_last, w_trig, w_cross;
    t_level               w_dev, w_thr, w_lvl, w_out_dev;
    logic                 w_started, w_done, w_verdict;

    assign w_cnt_inc     = r_cnt + 1'b1;
    assign w_cal_sum_inc = r_cal_sum + CAL_SUM_W'(i_sample);
    assign w_win_sum_inc = r_win_sum + WIN_SUM_W'(i_sample);
    assign w_cal_end     = (w_cnt_inc >= CAL_N);
    assign w_win_end     = (w_cnt_inc >= SPW_N);
    assign w_last        = (r_win_idx >= WIN_LAST);

    mec_cdiv #(
        .DIVISOR (CALIBRATION_SAMPLES),
        .IN_W    (CAL_SUM_W),
        .OUT_W   (SAMPLE_W)
    ) u_cal_div (
        .i_dividend (w_cal_sum_inc),
        .o_quotient (w_cal_avg)
    );

    mec_cdiv #(
        .DIVISOR (SAMPLES_PER_WINDOW),
        .IN_W    (WIN_SUM_W),
        .OUT_W   (SAMPLE_W)
    ) u_win_div (
        .i_dividend (w_win_sum_inc),
        .o_quotient (w_win_avg)
    );

    assign w_dev   = t_level'({1'b0, i_sample}) - t_level'({1'b0, r_baseline});
    assign w_thr   = t_level'({1'b0, i_cfg.trigger_threshold});
    assign w_trig  = (w_dev > w_thr) || (w_dev < -w_thr);
    assign w_lvl   = t_level'({1'b0, w_win_avg}) - t_level'({1'b0, r_baseline});
    assign w_cross = ((w_lvl >= 0) && (r_prev < 0)) || ((w_lvl <= 0) && (r_prev > 0));

    // next mode
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_CAL: begin
                if (w_cal_end) n_mode = MODE_WATCH;
            end
            MODE_WATCH: begin
                if (w_trig) n_mode = MODE_CAPTURE;
            end
            MODE_CAPTURE: begin
                if (w_win_end && w_last) n_mode = MODE_WATCH;
            end
            default: n_mode = MODE_CAL;
        endcase
    end

    // datapath and per-item outputs
    always_comb begin
        n_baseline   = r_baseline;
        n_cal_sum    = r_cal_sum;
        n_cnt        = r_cnt;
        n_win_idx    = r_win_idx;
        n_win_sum    = r_win_sum;
        n_prev       = r_prev;
        n_peak       = r_peak;
        n_trough     = r_trough;
        n_peak_win   = r_peak_win;
        n_trough_win = r_trough_win;
        n_rise       = r_rise;
        n_fall       = r_fall;
        n_cross      = r_cross;
        w_out_dev    = '0;
        w_started    = 1'b0;
        w_done       = 1'b0;
        case (r_mode)
            MODE_CAL: begin
                n_cal_sum = w_cal_sum_inc;
                n_cnt     = w_cnt_inc;
                if (w_cal_end) begin
                    n_baseline = w_cal_avg;
                    n_cnt      = '0;
                end
            end
            MODE_WATCH: begin
                w_out_dev = w_dev;
                if (w_trig) begin
                    n_prev       = w_dev;
                    n_peak       = w_dev;
                    n_trough     = w_dev;
                    n_peak_win   = '0;
                    n_trough_win = '0;
                    n_rise       = '0;
                    n_fall       = '0;
                    n_cross      = '0;
                    n_win_idx    = COUNT_W'(1);
                    n_win_sum    = '0;
                    n_cnt        = '0;
                    w_started    = 1'b1;
                end
            end
            MODE_CAPTURE: begin
                n_win_sum = w_win_sum_inc;
                n_cnt     = w_cnt_inc;
                if (w_win_end) begin
                    if (w_lvl < r_prev) begin
                        n_fall = r_fall + 1'b1;
                    end else if (w_lvl > r_prev) begin
                        n_rise = r_rise + 1'b1;
                    end
                    if (w_cross) n_cross = r_cross + 1'b1;
                    if (w_lvl >= r_peak) begin
                        n_peak     = w_lvl;
                        n_peak_win = r_win_idx;
                    end
                    if (w_lvl <= r_trough) begin
                        n_trough     = w_lvl;
                        n_trough_win = r_win_idx;
                    end
                    n_prev    = w_lvl;
                    n_win_sum = '0;
                    n_cnt     = '0;
                    if (w_last) begin
                        w_done    = 1'b1;
                        n_win_idx = COUNT_W'(1);
                    end else begin
                        n_win_idx = r_win_idx + 1'b1;
                    end
                end
                w_out_dev = n_prev;
            end
            default: ;
        endcase
    end

    assign w_verdict = (n_cross >= i_cfg.min_crossings) &&
                       (n_cross <= i_cfg.max_crossings) &&
                       (n_rise >= i_cfg.min_rising) &&
                       (n_fall <= i_cfg.max_falling) &&
                       (n_trough_win <= i_cfg.latest_min_time) &&
                       (n_peak_win >= n_trough_win) &&
                       (n_peak_win <= i_cfg.latest_max_time);

    always_comb begin
        o_result.phase         = n_mode;
        o_result.event_started = w_started;
        o_result.event_done    = w_done;
        o_result.detected      = w_done && w_verdict;
        o_result.deviation     = w_out_dev;
        o_result.crossings     = n_cross;
        o_result.rising_count  = n_rise;
        o_result.falling_count = n_fall;
        o_result.min_time      = n_trough_win;
        o_result.max_time      = n_peak_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_CAL;
            r_baseline   <= '0;
            r_cal_sum    <= '0;
            r_cnt        <= '0;
            r_win_idx    <= COUNT_W'(1);
            r_win_sum    <= '0;
            r_prev       <= '0;
            r_peak       <= '0;
            r_trough     <= '0;
            r_peak_win   <= '0;
            r_trough_win <= '0;
            r_rise       <= '0;
            r_fall       <= '0;
            r_cross      <= '0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_baseline   <= n_baseline;
            r_cal_sum    <= n_cal_sum;
            r_cnt        <= n_cnt;
            r_win_idx    <= n_win_idx;
            r_win_sum    <= n_win_sum;
            r_prev       <= n_prev;
            r_peak       <= n_peak;
            r_trough     <= n_trough;
            r_peak_win   <= n_peak_win;
            r_trough_win <= n_trough_win;
            r_rise       <= n_rise;
            r_fall       <= n_fall;
            r_cross      <= n_cross;
        end
    end

endmodule

`default_nettype wire

>>> dv/tb_magnetic_event_classifier_top.sv
// Self-checking bench for magnetic_event_classifier_top: drives sample items on the
// input stream, predicts phase, counters and verdict per item and checks each result.
// Depends on mec_pkg and the top level only.
`timescale 1ns / 1ps

module tb_magnetic_event_classifier_top;
    import mec_pkg::*;

    localparam int CAL_N       = 5;
    localparam int WIN_SAMPLES = 4;
    localparam int N_WINDOWS   = 49;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    magnetic_event_classifier_top #(
        .CALIBRATION_SAMPLES(CAL_N),
        .SAMPLES_PER_WINDOW (WIN_SAMPLES),
        .WINDOWS            (N_WINDOWS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // classifier image
    t_cfg  cfg;
    t_mode mode_m;
    int    baseline, cal_sum, smp_cnt, win_idx, win_sum;
    int    prev_lvl, peak_lvl, trough_lvl, peak_win, trough_win;
    int    rises, falls, xings;

    t_result         classifier_outputs_q[$];
    logic [9:0]      reg_image [8];
    int              src_idle_pct = 16;
    int              snk_idle_pct = 73;
    int              mismatch_count = 0;
    int              samples_sent = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [9:0] to_sample(input int v);
        if (v < 0) return 10'd0;
        if (v > 1023) return 10'd1023;
        return v[9:0];
    endfunction

    function automatic t_result classify_sample(input logic [9:0] s);
        t_result r;
        int lvl;
        int thr;
        r = '0;
        case (mode_m)
            MODE_CAL: begin
                cal_sum += int'(s);
                smp_cnt++;
                if (smp_cnt >= CAL_N) begin
                    baseline = cal_sum / CAL_N;
                    smp_cnt = 0;
                    mode_m = MODE_WATCH;
                end
                r.deviation = '0;
            end
            MODE_WATCH: begin
                thr = int'(cfg.trigger_threshold);
                lvl = int'(s) - baseline;
                r.deviation = t_level'(lvl);
                if (lvl > thr || lvl < -thr) begin
                    prev_lvl = lvl;
                    peak_lvl = lvl;
                    trough_lvl = lvl;
                    peak_win = 0;
                    trough_win = 0;
                    rises = 0;
                    falls = 0;
                    xings = 0;
                    win_idx = 1;
                    win_sum = 0;
                    smp_cnt = 0;
                    mode_m = MODE_CAPTURE;
                    r.event_started = 1'b1;
                end
            end
            default: begin
                win_sum += int'(s);
                smp_cnt++;
                if (smp_cnt >= WIN_SAMPLES) begin
                    lvl = win_sum / WIN_SAMPLES - baseline;
                    if (lvl < prev_lvl) falls++;
                    else if (lvl > prev_lvl) rises++;
                    if ((lvl >= 0 && prev_lvl < 0) || (lvl <= 0 && prev_lvl > 0)) xings++;
                    if (lvl >= peak_lvl) begin
                        peak_lvl = lvl;
                        peak_win = win_idx;
                    end
                    if (lvl <= trough_lvl) begin
                        trough_lvl = lvl;
                        trough_win = win_idx;
                    end
                    prev_lvl = lvl;
                    win_sum = 0;
                    smp_cnt = 0;
                    if (win_idx >= N_WINDOWS) begin
                        r.event_done = 1'b1;
                        r.detected = xings >= int'(cfg.min_crossings) &&
                                     xings <= int'(cfg.max_crossings) &&
                                     rises >= int'(cfg.min_rising) &&
                                     falls <= int'(cfg.max_falling) &&
                                     trough_win <= int'(cfg.latest_min_time) &&
                                     peak_win >= trough_win &&
                                     peak_win <= int'(cfg.latest_max_time);
                        mode_m = MODE_WATCH;
                        win_idx = 1;
                    end else begin
                        win_idx++;
                    end
                end
                r.deviation = t_level'(prev_lvl);
            end
        endcase
        r.phase         = mode_m;
        r.crossings     = xings[5:0];
        r.rising_count  = rises[5:0];
        r.falling_count = falls[5:0];
        r.min_time      = trough_win[5:0];
        r.max_time      = peak_win[5:0];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch on %0s: got %0d, want %0d", what, got, want);
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.phase         = o_m_axis_tdata[1:0];
            got.event_started = o_m_axis_tdata[2];
            got.detected      = o_m_axis_tdata[3];
            got.deviation     = o_m_axis_tdata[14:4];
            got.crossings     = o_m_axis_tdata[20:15];
            got.rising_count  = o_m_axis_tdata[26:21];
            got.falling_count = o_m_axis_tdata[32:27];
            got.min_time      = o_m_axis_tdata[38:33];
            got.max_time      = o_m_axis_tdata[44:39];
            got.event_done    = o_m_axis_tlast;
            if (classifier_outputs_q.size() == 0) begin
                note_mismatch("item with nothing pending", 0, 0);
            end else begin
                want = classifier_outputs_q.pop_front();
                if (got.phase !== want.phase)
                    note_mismatch("phase", got.phase, want.phase);
                if (got.event_started !== want.event_started)
                    note_mismatch("event_started", got.event_started, want.event_started);
                if (got.event_done !== want.event_done)
                    note_mismatch("event_done", got.event_done, want.event_done);
                if (got.detected !== want.detected)
                    note_mismatch("detected", got.detected, want.detected);
                if (got.deviation !== want.deviation)
                    note_mismatch("deviation", int'(got.deviation), int'(want.deviation));
                if (got.crossings !== want.crossings)
                    note_mismatch("crossings", got.crossings, want.crossings);
                if (got.rising_count !== want.rising_count)
                    note_mismatch("rising_count", got.rising_count, want.rising_count);
                if (got.falling_count !== want.falling_count)
                    note_mismatch("falling_count", got.falling_count, want.falling_count);
                if (got.min_time !== want.min_time)
                    note_mismatch("min_time", got.min_time, want.min_time);
                if (got.max_time !== want.max_time)
                    note_mismatch("max_time", got.max_time, want.max_time);
            end
        end
    end

    task automatic push_sample(input logic [9:0] s);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, s};
        do @(posedge i_clk); while (!o_s_axis_tready);
        classifier_outputs_q.push_back(classify_sample(s));
        samples_sent++;
    endtask

    task automatic settle_outputs();
        i_s_axis_tvalid <= 1'b0;
        while (classifier_outputs_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_config();
        settle_outputs();
        for (int r = 0; r < 8; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= r[2:0];
            i_cfg_data <= reg_image[r];
            @(posedge i_clk);
            case (r[2:0])
                CFG_TRIGGER_THRESHOLD: cfg.trigger_threshold = reg_image[r];
                CFG_MIN_CROSSINGS:     cfg.min_crossings     = reg_image[r][5:0];
                CFG_MAX_CROSSINGS:     cfg.max_crossings     = reg_image[r][5:0];
                CFG_MIN_RISING:        cfg.min_rising        = reg_image[r][5:0];
                CFG_MAX_FALLING:       cfg.max_falling       = reg_image[r][5:0];
                CFG_LATEST_MIN_TIME:   cfg.latest_min_time   = reg_image[r][5:0];
                CFG_LATEST_MAX_TIME:   cfg.latest_max_time   = reg_image[r][5:0];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [9:0] pick_limit();
        logic [5:0] v;
        case ($urandom_range(2))
            0:       v = 6'd0;
            1:       v = 6'd63;
            default: v = 6'($urandom_range(49));
        endcase
        return {4'($urandom_range(15)), v};
    endfunction

    task automatic watch_quiet(input int n);
        int thr;
        thr = int'(cfg.trigger_threshold);
        for (int k = 0; k < n && mode_m == MODE_WATCH; k++)
            push_sample(to_sample(baseline + $urandom_range(0, 2 * thr) - thr));
    endtask

    task automatic run_event(input bit shaped);
        int thr, start, lvl, a, b, trough_w, peak_w;
        bit up;
        thr = int'(cfg.trigger_threshold);
        up = $urandom_range(3) != 0;
        if (up && baseline + thr + 1 > 1023) up = 1'b0;
        if (!up && baseline - thr - 1 < 0) up = 1'b1;
        if (up) start = thr + 1 + $urandom_range(0, (1023 - baseline - thr - 1) / 2);
        else    start = -thr - 1 - $urandom_range(0, (baseline - thr - 1) / 2);
        push_sample(to_sample(baseline + start));
        trough_w = $urandom_range(2, 25);
        peak_w   = $urandom_range(trough_w + 5, 47);
        a        = $urandom_range(30, 450);
        b        = $urandom_range(30, 450);
        while (mode_m == MODE_CAPTURE) begin
            if (!shaped)
                lvl = $urandom_range(0, 800) - 400;
            else if (win_idx <= trough_w)
                lvl = start + (-a - start) * win_idx / trough_w;
            else if (win_idx <= peak_w)
                lvl = -a + (a + b) * (win_idx - trough_w) / (peak_w - trough_w);
            else
                lvl = b + $urandom_range(0, 20) - 10;
            if ($urandom_range(19) == 0)
                push_sample(10'($urandom_range(1023)));
            else
                push_sample(to_sample(baseline + lvl + $urandom_range(0, 6) - 3));
        end
    endtask

    task automatic test_calibration();
        reg_image = '{10'd1023, 10'd2, 10'd7, 10'd10, 10'd30, 10'd30, 10'd45, 10'd511};
        apply_config();
        push_sample(10'd1023);
        push_sample(10'd0);
        push_sample(10'h2AA);
        push_sample(10'h155);
        push_sample(10'd512);
    endtask

    task automatic test_threshold_extremes();
        // widest threshold: nothing triggers, not even the rails
        push_sample(10'd0);
        push_sample(10'd1023);
        reg_image[0] = 10'd0;
        apply_config();
        push_sample(to_sample(baseline));
        push_sample(to_sample(baseline + 1));
    endtask

    task automatic test_window_steps();
        repeat (4) push_sample(10'd0);
        repeat (4) push_sample(10'd1023);
        repeat (4) push_sample(to_sample(baseline));
        // equal level: no step and no crossing
        repeat (4) push_sample(to_sample(baseline));
    endtask

    task automatic test_config_during_event();
        reg_image = '{10'd5, 10'd0, 10'd63, 10'd0, 10'd63, 10'd63, 10'd63, 10'd0};
        apply_config();
        while (mode_m == MODE_CAPTURE) begin
            if ($urandom_range(3) == 0)
                push_sample(10'($urandom_range(1023)));
            else
                push_sample(to_sample(baseline + $urandom_range(0, 200) - 100));
        end
    endtask

    task automatic test_random_events(input int snd, input int rcv, input int flavour,
                                      input int events);
        src_idle_pct = snd;
        snk_idle_pct = rcv;
        case (flavour)
            0: reg_image = '{10'($urandom_range(3, 60)), 10'd2, 10'd7, 10'd10,
                             10'd30, 10'd30, 10'd45, 10'($urandom_range(1023))};
            1: reg_image = '{10'($urandom_range(0, 400)), pick_limit(), pick_limit(),
                             pick_limit(), pick_limit(), pick_limit(), pick_limit(),
                             10'($urandom_range(1023))};
            default: reg_image = '{10'($urandom_range(100, 450)), 10'd0, 10'd49, 10'd0,
                                   10'd49, 10'd49, 10'd49, 10'($urandom_range(1023))};
        endcase
        apply_config();
        for (int e = 0; e < events; e++) begin
            watch_quiet($urandom_range(4, 16));
            run_event(flavour != 1);
        end
        watch_quiet($urandom_range(2, 8));
    endtask

    initial begin
        cfg = '{trigger_threshold: 10'd5, min_crossings: 6'd2, max_crossings: 6'd7,
                min_rising: 6'd10, max_falling: 6'd30, latest_min_time: 6'd30,
                latest_max_time: 6'd45};
        mode_m = MODE_CAL;
        baseline = 0; cal_sum = 0; smp_cnt = 0; win_idx = 1; win_sum = 0;
        prev_lvl = 0; peak_lvl = 0; trough_lvl = 0; peak_win = 0; trough_win = 0;
        rises = 0; falls = 0; xings = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_calibration();
        test_threshold_extremes();
        test_window_steps();
        test_config_during_event();
        test_random_events(16, 73, 0, 0);
        test_random_events(73, 16, 1, 1);
        test_random_events(0, 0, 2, 1);

        settle_outputs();
        if (mismatch_count == 0 && classifier_outputs_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
